/* src/slms_pkg.sv */
// shared types and constants for the scrolling led matrix scanner
`default_nettype none

package slms_pkg;

   localparam int GLYPH_SIZE  = 16;
   localparam int MAX_CHARS   = 16;
   localparam int PANEL_CHARS = 3;
   localparam int NUM_BANKS   = 4;
   localparam int BANK_DEPTH  = (MAX_CHARS / NUM_BANKS) * GLYPH_SIZE;
   localparam int BANK_ADDR_W = 6;
   localparam int CFG_IDX_W   = 8;
   localparam int CFG_DATA_W  = 8;

   localparam logic                  FUNC_WRITE = 1'b0;
   localparam logic                  FUNC_TICK  = 1'b1;
   localparam logic [CFG_IDX_W-1:0]  CFG_MSG_LEN = 8'd0;
   localparam logic [CFG_IDX_W-1:0]  CFG_FRAMES  = 8'd1;

   localparam logic [4:0]  MSG_LEN_RESET = 5'd9;
   localparam logic [7:0]  FRAMES_RESET  = 8'd12;
   localparam logic [4:0]  MSG_LEN_MIN   = 5'd3;
   localparam logic [4:0]  MSG_LEN_MAX   = 5'd16;
   localparam logic [15:0] ROW_TOP       = 16'h8000;

   typedef logic [3:0]  row_type;
   typedef logic [3:0]  char_type;
   typedef logic [15:0] glyph_type;
   typedef logic [7:0]  scroll_type;

   typedef struct packed {
      row_type                row;
      scroll_type             scroll;
      logic [1:0]             base_lo;
      logic [NUM_BANKS-1:0]   char_ok;
   } stage_type;

endpackage

`default_nettype wire

/* src/slms_if.sv */
// item channel interfaces for glyph writes and ticks, scan results and register writes
`default_nettype none

interface slms_req_if;
   logic                 valid;
   logic                 ready;
   logic                 func;
   slms_pkg::char_type   glyph_char;
   slms_pkg::row_type    glyph_row;
   slms_pkg::glyph_type  glyph_bits;
   modport source (output valid, func, glyph_char, glyph_row, glyph_bits, input ready);
   modport sink   (input valid, func, glyph_char, glyph_row, glyph_bits, output ready);
endinterface

interface slms_rsp_if;
   logic                  valid;
   logic                  ready;
   slms_pkg::row_type     row_index;
   logic [15:0]           anode_drive_n;
   logic [47:0]           pixels;
   slms_pkg::scroll_type  scroll_column;
   modport source (output valid, row_index, anode_drive_n, pixels, scroll_column, input ready);
   modport sink   (input valid, row_index, anode_drive_n, pixels, scroll_column, output ready);
endinterface

interface slms_csr_if;
   logic                                valid;
   logic                                ready;
   logic [slms_pkg::CFG_IDX_W-1:0]      index;
   logic [slms_pkg::CFG_DATA_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/slms_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module slms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                      clock,
   input  wire logic                      we,
   input  wire logic [$clog2(DEPTH)-1:0]  waddr,
   input  wire logic [WIDTH-1:0]          wdata,
   input  wire logic                      re,
   input  wire logic [$clog2(DEPTH)-1:0]  raddr,
   output      logic [WIDTH-1:0]          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* src/slms_scan_ctrl.sv */
// registers, scan counters, glyph valid bits and bank write and read addressing
`default_nettype none

module slms_scan_ctrl (
   input  wire logic                                               clock,
   input  wire logic                                               reset,
   slms_req_if.sink                                                req,
   slms_csr_if.sink                                                csr,
   input  wire logic                                               take,
   output      logic [slms_pkg::NUM_BANKS-1:0]                     ram_we,
   output      logic [slms_pkg::BANK_ADDR_W-1:0]                   ram_waddr,
   output      slms_pkg::glyph_type                                ram_wdata,
   output      logic [slms_pkg::NUM_BANKS-1:0]                     ram_re,
   output      logic [slms_pkg::NUM_BANKS-1:0][slms_pkg::BANK_ADDR_W-1:0] ram_raddr,
   output      slms_pkg::stage_type                                stage,
   output      logic                                               stage_valid
);

   localparam int NUM_OK = slms_pkg::NUM_BANKS;

   logic [4:0]             msg_len_ff, msg_len_in;
   logic [7:0]             frames_ff, frames_in;
   slms_pkg::row_type      row_ff, row_in;
   logic [7:0]             frame_ff, frame_in;
   slms_pkg::scroll_type   scroll_ff, scroll_in;
   logic [255:0]           valid_ff, valid_in;
   logic                   stage_valid_ff, stage_valid_in;
   slms_pkg::stage_type    stage_ff, stage_in;

   logic                   accept, tick, wr;
   logic [4:0]             eff_len;
   logic [7:0]             fps;
   logic [7:0]             limit;
   logic [8:0]             frame_inc, scroll_inc;
   logic [3:0]             base;
   logic [NUM_OK-1:0]      ok;

   assign req.ready = !stage_valid_ff || take;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;
   assign tick      = accept && (req.func == slms_pkg::FUNC_TICK);
   assign wr        = accept && (req.func == slms_pkg::FUNC_WRITE);
   assign base      = scroll_ff[7:4];

   // clamped register values
   always_comb begin
      eff_len = msg_len_ff;
      if (msg_len_ff < slms_pkg::MSG_LEN_MIN) begin
         eff_len = slms_pkg::MSG_LEN_MIN;
      end else if (msg_len_ff > slms_pkg::MSG_LEN_MAX) begin
         eff_len = slms_pkg::MSG_LEN_MAX;
      end
      fps   = (frames_ff == 8'd0) ? 8'd1 : frames_ff;
      limit = {eff_len[3:0] - 4'd2, 4'd0};
      if (eff_len == slms_pkg::MSG_LEN_MAX) begin
         limit = 8'd224;
      end
   end

   // write side
   always_comb begin
      for (int k = 0; k < slms_pkg::NUM_BANKS; k++) begin
         ram_we[k] = wr && (req.glyph_char[1:0] == 2'(k));
      end
   end
   assign ram_waddr = {req.glyph_char[3:2], req.glyph_row};
   assign ram_wdata = req.glyph_bits;

   // each bank holds every fourth character; one read per bank covers the panel
   always_comb begin
      logic [1:0] off;
      logic [4:0] ch;
      for (int k = 0; k < slms_pkg::NUM_BANKS; k++) begin
         off          = 2'(k) - base[1:0];
         ch           = {1'b0, base} + {3'b000, off};
         ram_raddr[k] = {ch[3:2], row_ff};
         ok[k]        = (ch < eff_len) && valid_ff[{ch[3:0], row_ff}];
      end
   end
   assign ram_re = {slms_pkg::NUM_BANKS{tick}};

   // registers, counters, glyph valid bits and the stage register
   always_comb begin
      msg_len_in = msg_len_ff;
      frames_in  = frames_ff;
      if (csr.valid && (csr.index == slms_pkg::CFG_MSG_LEN)) begin
         msg_len_in = csr.data[4:0];
      end
      if (csr.valid && (csr.index == slms_pkg::CFG_FRAMES)) begin
         frames_in = csr.data;
      end

      frame_inc  = {1'b0, frame_ff} + 9'd1;
      scroll_inc = {1'b0, scroll_ff} + 9'd1;
      row_in     = row_ff;
      frame_in   = frame_ff;
      scroll_in  = scroll_ff;
      if (tick) begin
         row_in = row_ff + 4'd1;
         if (row_ff == 4'd15) begin
            if (frame_inc >= {1'b0, fps}) begin
               frame_in  = 8'd0;
               scroll_in = (scroll_inc >= {1'b0, limit}) ? 8'd0 : scroll_inc[7:0];
            end else begin
               frame_in = frame_inc[7:0];
            end
         end
      end

      valid_in = valid_ff;
      if (wr) begin
         valid_in[{req.glyph_char, req.glyph_row}] = 1'b1;
      end

      stage_valid_in = tick || (stage_valid_ff && !take);
      stage_in       = stage_ff;
      if (tick) begin
         stage_in.row     = row_ff;
         stage_in.scroll  = scroll_ff;
         stage_in.base_lo = base[1:0];
         stage_in.char_ok = ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_len_ff     <= slms_pkg::MSG_LEN_RESET;
         frames_ff      <= slms_pkg::FRAMES_RESET;
         row_ff         <= '0;
         frame_ff       <= '0;
         scroll_ff      <= '0;
         valid_ff       <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         msg_len_ff     <= msg_len_in;
         frames_ff      <= frames_in;
         row_ff         <= row_in;
         frame_ff       <= frame_in;
         scroll_ff      <= scroll_in;
         valid_ff       <= valid_in;
         stage_valid_ff <= stage_valid_in;
      end
      stage_ff <= stage_in;
   end

   assign stage       = stage_ff;
   assign stage_valid = stage_valid_ff;

endmodule

`default_nettype wire

/* src/slms_pixel_merge.sv */
// funnel shifts of neighbouring glyph rows into the result register
`default_nettype none

module slms_pixel_merge (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire slms_pkg::stage_type                          stage,
   input  wire logic                                         stage_valid,
   input  wire logic [slms_pkg::NUM_BANKS-1:0][15:0]         rdata,
   output      logic                                         take,
   slms_rsp_if.source                                        rsp
);

   logic                   rsp_valid_ff, rsp_valid_in;
   slms_pkg::row_type      row_ff, row_in;
   logic [15:0]            anode_ff, anode_in;
   logic [47:0]            pixels_ff, pixels_in;
   slms_pkg::scroll_type   scroll_ff, scroll_in;
   logic                   load;
   logic [47:0]            pix;

   assign take = !rsp_valid_ff || rsp.ready;
   assign load = stage_valid && take;

   always_comb begin
      logic [1:0]  lb, rb;
      logic [15:0] left, right;
      logic [31:0] window;
      pix = '0;
      for (int p = 0; p < slms_pkg::PANEL_CHARS; p++) begin
         lb     = stage.base_lo + 2'(p);
         rb     = lb + 2'd1;
         left   = stage.char_ok[lb] ? rdata[lb] : 16'd0;
         right  = stage.char_ok[rb] ? rdata[rb] : 16'd0;
         window = {left, right} << stage.scroll[3:0];
         pix    = {pix[31:0], window[31:16]};
      end
   end

   always_comb begin
      rsp_valid_in = load || (rsp_valid_ff && !rsp.ready);
      row_in       = row_ff;
      anode_in     = anode_ff;
      pixels_in    = pixels_ff;
      scroll_in    = scroll_ff;
      if (load) begin
         row_in    = stage.row;
         anode_in  = ~(slms_pkg::ROW_TOP >> stage.row);
         pixels_in = pix;
         scroll_in = stage.scroll;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff    <= row_in;
      anode_ff  <= anode_in;
      pixels_ff <= pixels_in;
      scroll_ff <= scroll_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.row_index     = row_ff;
   assign rsp.anode_drive_n = anode_ff;
   assign rsp.pixels        = pixels_ff;
   assign rsp.scroll_column = scroll_ff;

endmodule

`default_nettype wire

/* src/scrolling_led_matrix_scanner_unit.sv */
// top level of the scrolling led matrix scanner
//
// Scans a 16-row panel three 16x16 glyphs wide and scrolls a stored message
// across it. A write item (func 0) stores one glyph row and gives no result; a
// tick item (func 1) gives one result with the row index, active-low anode
// drive, 48 pixel bits and the scroll column, then advances the row, frame and
// scroll counters. One item is taken every cycle unless the result port stalls;
// a tick's glyph rows are read from the banks as it is taken, then the funnel
// shift result register loads them, holding while the result port stalls.
// The glyph store is four banks of 64 rows, one per character modulo four, so
// the four characters a tick needs are read in parallel. A valid bit per store
// row makes the store read as blank after reset, so no clearing pass is needed.
// Register 0 is the message length, register 1 the frames per scroll step;
// write them only while the block is idle.
`default_nettype none

module scrolling_led_matrix_scanner_unit (
   input  wire logic    clock,
   input  wire logic    reset,
   slms_req_if.sink     req_ch,
   slms_rsp_if.source   rsp_ch,
   slms_csr_if.sink     csr_ch
);

   logic [slms_pkg::NUM_BANKS-1:0]                              ram_we;
   logic [slms_pkg::BANK_ADDR_W-1:0]                            ram_waddr;
   slms_pkg::glyph_type                                         ram_wdata;
   logic [slms_pkg::NUM_BANKS-1:0]                              ram_re;
   logic [slms_pkg::NUM_BANKS-1:0][slms_pkg::BANK_ADDR_W-1:0]   ram_raddr;
   logic [slms_pkg::NUM_BANKS-1:0][15:0]                        ram_rdata;
   slms_pkg::stage_type                                         stage;
   logic                                                        stage_valid;
   logic                                                        take;

   slms_scan_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .csr         (csr_ch),
      .take        (take),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_re      (ram_re),
      .ram_raddr   (ram_raddr),
      .stage       (stage),
      .stage_valid (stage_valid)
   );

   for (genvar k = 0; k < slms_pkg::NUM_BANKS; k++) begin : g_bank
      slms_ram #(
         .WIDTH (16),
         .DEPTH (slms_pkg::BANK_DEPTH)
      ) u_bank (
         .clock (clock),
         .we    (ram_we[k]),
         .waddr (ram_waddr),
         .wdata (ram_wdata),
         .re    (ram_re[k]),
         .raddr (ram_raddr[k]),
         .rdata (ram_rdata[k])
      );
   end

   slms_pixel_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage),
      .stage_valid (stage_valid),
      .rdata       (ram_rdata),
      .take        (take),
      .rsp         (rsp_ch)
   );

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// self-checking testbench for the scrolling led matrix scanner unit
`timescale 1ns / 100ps

module tb;
   import slms_pkg::*;

   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 6;
   localparam int REPORT_MAX   = 10;

   localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 8'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 8'hFF;

   typedef struct packed {
      logic       func;
      char_type   ch;
      row_type    row;
      glyph_type  bits;
   } glyph_cmd_type;

   typedef struct packed {
      row_type      row;
      logic [15:0]  anode_n;
      logic [47:0]  pixels;
      scroll_type   scroll;
   } scan_row_type;

   logic clock = 1'b0;
   logic reset;

   slms_req_if req_bus ();
   slms_rsp_if rsp_bus ();
   slms_csr_if csr_bus ();

   scrolling_led_matrix_scanner_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // marquee state as the block should hold it
   glyph_type   glyph_mem [0:MAX_CHARS*GLYPH_SIZE-1];
   scroll_type  scroll_pos;
   logic [7:0]  frame_cnt;
   row_type     row_cnt;
   logic [4:0]  msg_len;
   logic [7:0]  frames_cfg;

   glyph_cmd_type  cmd_queue [$];
   scan_row_type   pending_scans [$];
   glyph_cmd_type  on_bus;
   int          cmds_in_flight = 0;
   int          send_idle_pct  = 0;
   int          stall_pct      = 0;
   int          failures       = 0;
   int          quiet_cycles   = 0;
   int          writes_sent    = 0;
   int          ticks_sent     = 0;
   int          scans_checked  = 0;
   int          csr_writes     = 0;
   int          top_scroll     = 0;

   task automatic reset_marquee();
      foreach (glyph_mem[i]) glyph_mem[i] = '0;
      scroll_pos = '0;
      frame_cnt  = '0;
      row_cnt    = '0;
      msg_len    = MSG_LEN_RESET;
      frames_cfg = FRAMES_RESET;
   endtask

   function automatic int unsigned length_in_use();
      int unsigned n;
      n = msg_len;
      if (n < MSG_LEN_MIN) n = MSG_LEN_MIN;
      if (n > MSG_LEN_MAX) n = MSG_LEN_MAX;
      return n;
   endfunction

   function automatic glyph_type glyph_at(int unsigned ch, row_type r);
      if (ch >= length_in_use() || ch >= MAX_CHARS) return '0;
      return glyph_mem[ch*GLYPH_SIZE + r];
   endfunction

   task automatic marquee_step(input glyph_cmd_type cmd);
      int unsigned base;
      int unsigned shift;
      int unsigned limit;
      int unsigned fps;
      logic [31:0] pair;
      scan_row_type want;
      if (cmd.func == FUNC_WRITE) begin
         glyph_mem[cmd.ch*GLYPH_SIZE + cmd.row] = cmd.bits;
         writes_sent++;
      end else begin
         ticks_sent++;
         base  = scroll_pos / GLYPH_SIZE;
         shift = scroll_pos % GLYPH_SIZE;
         want.row     = row_cnt;
         want.anode_n = ~(ROW_TOP >> row_cnt);
         want.scroll  = scroll_pos;
         want.pixels  = '0;
         for (int p = 0; p < PANEL_CHARS; p++) begin
            pair = {glyph_at(base + p, row_cnt), glyph_at(base + p + 1, row_cnt)} << shift;
            want.pixels = {want.pixels[31:0], pair[31:16]};
         end
         pending_scans.push_back(want);
         if (scroll_pos > top_scroll) top_scroll = scroll_pos;
         if (row_cnt == row_type'(GLYPH_SIZE - 1)) begin
            row_cnt   = '0;
            fps       = (frames_cfg == 0) ? 1 : frames_cfg;
            frame_cnt = frame_cnt + 1;
            if (frame_cnt >= fps) begin
               frame_cnt  = '0;
               limit      = GLYPH_SIZE * (length_in_use() - 2);
               scroll_pos = scroll_pos + 1;
               if (scroll_pos >= limit) scroll_pos = '0;
            end
         end else begin
            row_cnt = row_cnt + 1;
         end
      end
   endtask

   task automatic log_error(input string msg);
      failures++;
      if (failures <= REPORT_MAX) $display("error: %s", msg);
   endtask

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.func       <= FUNC_WRITE;
         req_bus.glyph_char <= '0;
         req_bus.glyph_row  <= '0;
         req_bus.glyph_bits <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            marquee_step(on_bus);
            cmds_in_flight--;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_bus = cmd_queue.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.func       <= on_bus.func;
               req_bus.glyph_char <= on_bus.ch;
               req_bus.glyph_row  <= on_bus.row;
               req_bus.glyph_bits <= on_bus.bits;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_scan();
      scan_row_type got;
      scan_row_type want;
      got.row     = rsp_bus.row_index;
      got.anode_n = rsp_bus.anode_drive_n;
      got.pixels  = rsp_bus.pixels;
      got.scroll  = rsp_bus.scroll_column;
      if (pending_scans.size() == 0) begin
         log_error($sformatf("unexpected scan row: row %0d anode %h pixels %h scroll %0d",
                             got.row, got.anode_n, got.pixels, got.scroll));
      end else begin
         want = pending_scans.pop_front();
         scans_checked++;
         if (got !== want)
            log_error($sformatf({"scan row mismatch: expected row %0d anode %h pixels %h ",
                                 "scroll %0d, got row %0d anode %h pixels %h scroll %0d"},
                                want.row, want.anode_n, want.pixels, want.scroll,
                                got.row, got.anode_n, got.pixels, got.scroll));
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_scan();
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic push_cmd(input logic func, input int ch, input int row, input int bits);
      glyph_cmd_type c;
      c.func = func;
      c.ch   = char_type'(ch);
      c.row  = row_type'(row);
      c.bits = glyph_type'(bits);
      cmd_queue.push_back(c);
      cmds_in_flight++;
   endtask

   task automatic wait_quiet();
      do @(posedge clock); while (cmds_in_flight != 0 || pending_scans.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      if (idx == CFG_MSG_LEN) msg_len = val[4:0];
      else if (idx == CFG_FRAMES) frames_cfg = val;
      csr_writes++;
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // glyph load followed by a tick-heavy mix with writes during display
   task automatic run_phase(input logic [7:0] len_val, input logic [7:0] fps_val,
                            input int idle, input int stall, input int n_load, input int n_mixed);
      int unsigned last_ch;
      wait_quiet();
      write_csr(CFG_MSG_LEN, len_val);
      write_csr(CFG_FRAMES, fps_val);
      send_idle_pct = idle;
      stall_pct     = stall;
      last_ch = length_in_use();
      if (last_ch > MAX_CHARS - 1) last_ch = MAX_CHARS - 1;
      repeat (n_load)
         push_cmd(FUNC_WRITE, $urandom_range(last_ch), $urandom_range(15), $urandom);
      repeat (n_mixed)
         push_cmd(($urandom_range(99) < 15) ? FUNC_WRITE : FUNC_TICK,
                  $urandom_range(15), $urandom_range(15), $urandom);
   endtask

   initial begin
      reset              <= 1'b1;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= '0;
      csr_bus.data       <= '0;
      reset_marquee();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset register values, corners of the store, blanks past the message end
      push_cmd(FUNC_WRITE, 0, 0, 16'hFFFF);
      push_cmd(FUNC_WRITE, 1, 0, 16'h8001);
      push_cmd(FUNC_WRITE, 2, 0, 16'h7FFE);
      push_cmd(FUNC_WRITE, 3, 0, 16'hAAAA);
      push_cmd(FUNC_WRITE, 0, 1, 16'h5555);
      push_cmd(FUNC_WRITE, 8, 1, 16'h1234);
      push_cmd(FUNC_WRITE, 9, 1, 16'hFFFF);
      push_cmd(FUNC_WRITE, 15, 15, 16'hFFFF);
      for (int t = 0; t < 16; t++) begin
         push_cmd(FUNC_TICK, 0, 0, 0);
         if (t == 3) push_cmd(FUNC_WRITE, 0, 15, 16'hC3C3);
      end

      run_phase(8'd3,   8'd1,   0,  0,  40, 210);
      run_phase(8'd16,  8'd1,  70,  0,  60, 340);
      run_phase(8'd0,   8'd0,   0, 70,  10,  60);
      run_phase(8'hFF,  8'd255, 33, 33, 30, 120);
      run_phase(8'd17,  8'd2,   0,  0,  30, 150);
      wait_quiet();
      write_csr(CFG_SPARE_LO, 8'h05);
      write_csr(CFG_SPARE_HI, 8'h01);
      run_phase(8'd9,   8'd12,  0, 70,  20, 130);
      run_phase(8'd1,   8'd1,  70,  0,  10, 120);
      wait_quiet();

      $display("%0d items sent (%0d glyph writes, %0d ticks), %0d register writes",
               writes_sent + ticks_sent, writes_sent, ticks_sent, csr_writes);
      $display("%0d scan rows checked, highest scroll column %0d, %0d errors",
               scans_checked, top_scroll, failures);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
src/slms_pkg.sv
src/slms_if.sv
src/slms_ram.sv
src/slms_scan_ctrl.sv
src/slms_pixel_merge.sv
src/scrolling_led_matrix_scanner_unit.sv
tb/sv/tb.sv
